// ----- rtl/core/rpn_pkg.sv -----
package rpn_pkg;

    localparam int VAL_W = 64;

    typedef enum logic [1:0] {
        MODE_PUSH = 2'd0,
        MODE_OP   = 2'd1,
        MODE_END  = 2'd2,
        MODE_NONE = 2'd3
    } mode_t;

    typedef enum logic [4:0] {
        OP_IF   = 5'd0,
        OP_ADD  = 5'd1,
        OP_SUB  = 5'd2,
        OP_MUL  = 5'd3,
        OP_DIV  = 5'd4,
        OP_REM  = 5'd5,
        OP_AND  = 5'd6,
        OP_OR   = 5'd7,
        OP_XOR  = 5'd8,
        OP_LT   = 5'd9,
        OP_LE   = 5'd10,
        OP_EQ   = 5'd11,
        OP_NE   = 5'd12,
        OP_GE   = 5'd13,
        OP_GT   = 5'd14,
        OP_LSH  = 5'd15,
        OP_RSH  = 5'd16,
        OP_LOG  = 5'd17,
        OP_NOT  = 5'd18,
        OP_DUP  = 5'd19,
        OP_DROP = 5'd20
    } opcode_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_UNDER = 2'd1,
        ST_OVER  = 2'd2,
        ST_COUNT = 2'd3
    } status_t;

endpackage

// ----- rtl/core/rpn_ram.sv -----
module rpn_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- rtl/core/rpn_stack_evaluator.sv -----
// Postfix evaluator over a stack of 64-bit unsigned values.
// Input beats on s_axis: tuser = mode; tdata = {push_value, opcode} from the
// lowest bit up, padded to 72 bits. Mode push stores a value, mode op applies
// an operator to the top entries, mode end closes the expression.
// Only the end beat produces a result beat on m_axis: tdata =
// {result_value, status} from the lowest bit up, padded to 72 bits.
// A push leaves the block ready for the next beat; an end passes through the
// end and output states, then waits out any output stall. Operators read
// their operands one at a time from the stack RAM, each through a read and a
// wait state (up to 3 reads), run on one shared ALU, then write back. Add,
// logic, compare, shift, if, not, dup and drop pass the ALU state once;
// mul, div and rem iterate one bit per cycle and log scans one bit per cycle.
// The result beat sits in an output register; while the receiver stalls,
// the block waits for m_axis_tready before taking the next input beat.
// Reset (aresetn low, synchronous) empties the stack and clears the error.
// Stack storage needs no clearing pass: only written entries are read.
module rpn_stack_evaluator
    import rpn_pkg::*;
#(
    parameter int STACK_DEPTH = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [71:0] s_axis_tdata,   // push_value[63:0], opcode[68:64]
    input  logic [1:0]  s_axis_tuser,   // mode[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [71:0] m_axis_tdata    // result_value[63:0], status[65:64]
);

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int DW = $clog2(STACK_DEPTH + 1);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_READ  = 7'b0000010,
        S_WAIT  = 7'b0000100,
        S_ITER  = 7'b0001000,
        S_WRITE = 7'b0010000,
        S_END   = 7'b0100000,
        S_OUT   = 7'b1000000
    } state_t;

    state_t            state_reg, state_next;
    logic [DW-1:0]     depth_reg, depth_next;
    status_t           err_reg, err_next;
    logic [4:0]        opc_reg, opc_next;
    logic [1:0]        rcnt_reg, rcnt_next;
    logic [1:0]        need_reg, need_next;
    logic [VAL_W-1:0]  a_reg, a_next, b_reg, b_next, c_reg, c_next;
    logic [VAL_W-1:0]  acc_reg, acc_next, rem_reg, rem_next;
    logic [6:0]        cnt_reg, cnt_next;
    logic [VAL_W-1:0]  res_reg, res_next;
    logic [1:0]        st_reg, st_next;
    logic              mv_reg, mv_next;

    logic              we;
    logic [AW-1:0]     waddr, raddr;
    logic [VAL_W-1:0]  wdata, rdata;

    logic [1:0]        in_mode;
    logic [VAL_W-1:0]  in_val;
    logic [4:0]        in_opc;
    logic [1:0]        need;
    logic [VAL_W:0]    rtrial;
    logic [VAL_W-1:0]  rsh;

    assign in_mode = s_axis_tuser;
    assign in_val  = s_axis_tdata[63:0];
    assign in_opc  = s_axis_tdata[68:64];

    assign s_axis_tready = (state_reg == S_IDLE) && !mv_reg;
    assign m_axis_tvalid = mv_reg;
    assign m_axis_tdata  = {6'd0, st_reg, res_reg};

    assign rtrial = {rem_reg, a_reg[VAL_W-1]} - {1'b0, b_reg};

    always_comb begin
        unique case (in_opc)
            OP_IF:                          need = 2'd3;
            OP_LOG, OP_NOT, OP_DUP, OP_DROP: need = 2'd1;
            default:                        need = (in_opc <= OP_RSH) ? 2'd2 : 2'd0;
        endcase
    end

    rpn_ram #(.WIDTH(VAL_W), .DEPTH(STACK_DEPTH)) u_stack (
        .aclk  (aclk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    always_comb begin
        rsh = a_reg >> b_reg[5:0];
        state_next = state_reg;
        depth_next = depth_reg;
        err_next   = err_reg;
        opc_next   = opc_reg;
        rcnt_next  = rcnt_reg;
        need_next  = need_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        c_next     = c_reg;
        acc_next   = acc_reg;
        rem_next   = rem_reg;
        cnt_next   = cnt_reg;
        res_next   = res_reg;
        st_next    = st_reg;
        mv_next    = mv_reg && !m_axis_tready;
        we         = 1'b0;
        waddr      = depth_reg[AW-1:0];
        wdata      = a_reg;
        raddr      = AW'(depth_reg - DW'(rcnt_reg) - DW'(1));
        unique case (state_reg)
            S_IDLE: begin
                if (s_axis_tvalid && s_axis_tready) begin
                    priority if (in_mode == MODE_END) begin
                        if (err_reg == ST_OK && depth_reg == DW'(1)) begin
                            raddr = '0;
                            st_next = ST_OK;
                        end else begin
                            st_next = (err_reg == ST_OK) ? ST_COUNT : err_reg;
                        end
                        state_next = S_END;
                    end else if (in_mode == MODE_NONE || err_reg != ST_OK) begin
                    end else if (depth_reg >= DW'(STACK_DEPTH - 1)) begin
                        err_next = ST_OVER;
                    end else if (in_mode == MODE_PUSH) begin
                        we = 1'b1;
                        wdata = in_val;
                        depth_next = depth_reg + DW'(1);
                    end else if (need == 2'd0) begin
                    end else if (depth_reg < DW'(need)) begin
                        err_next = ST_UNDER;
                    end else begin
                        opc_next  = in_opc;
                        need_next = need;
                        rcnt_next = 2'd0;
                        state_next = S_READ;
                    end
                end
            end
            S_READ: begin
                rcnt_next = rcnt_reg + 2'd1;
                state_next = S_WAIT;
            end
            S_WAIT: begin
                // data arriving is entry depth-rcnt (top first)
                unique case (rcnt_reg)
                    2'd1:    begin
                        if (need_reg == 2'd1) a_next = rdata;
                        else if (need_reg == 2'd2) b_next = rdata;
                        else c_next = rdata;
                    end
                    2'd2:    begin
                        if (need_reg == 2'd2) a_next = rdata;
                        else b_next = rdata;
                    end
                    default: a_next = rdata;
                endcase
                if (rcnt_reg == need_reg) begin
                    state_next = S_ITER;
                    acc_next = '0;
                    rem_next = '0;
                    cnt_next = '0;
                end else begin
                    state_next = S_READ;
                end
            end
            S_ITER: begin
                state_next = S_WRITE;
                unique case (opc_reg)
                    OP_IF:  res_next = (c_reg != '0) ? b_reg : a_reg;
                    OP_ADD: res_next = a_reg + b_reg;
                    OP_SUB: res_next = a_reg - b_reg;
                    OP_MUL: begin
                        if (b_reg[0]) acc_next = acc_reg + (a_reg << cnt_reg[5:0]);
                        b_next = b_reg >> 1;
                        cnt_next = cnt_reg + 7'd1;
                        res_next = acc_next;
                        if (cnt_reg != 7'd63) state_next = S_ITER;
                    end
                    OP_DIV, OP_REM: begin
                        if (b_reg == '0) begin
                            res_next = (opc_reg == OP_DIV) ? '1 : a_reg;
                        end else begin
                            if (!rtrial[VAL_W]) rem_next = rtrial[VAL_W-1:0];
                            else rem_next = {rem_reg[VAL_W-2:0], a_reg[VAL_W-1]};
                            acc_next = {acc_reg[VAL_W-2:0], ~rtrial[VAL_W]};
                            a_next = a_reg << 1;
                            cnt_next = cnt_reg + 7'd1;
                            res_next = (opc_reg == OP_DIV) ? acc_next : rem_next;
                            if (cnt_reg != 7'd63) state_next = S_ITER;
                        end
                    end
                    OP_AND: res_next = a_reg & b_reg;
                    OP_OR:  res_next = a_reg | b_reg;
                    OP_XOR: res_next = a_reg ^ b_reg;
                    OP_LT:  res_next = VAL_W'(a_reg < b_reg);
                    OP_LE:  res_next = VAL_W'(a_reg <= b_reg);
                    OP_EQ:  res_next = VAL_W'(a_reg == b_reg);
                    OP_NE:  res_next = VAL_W'(a_reg != b_reg);
                    OP_GE:  res_next = VAL_W'(a_reg >= b_reg);
                    OP_GT:  res_next = VAL_W'(a_reg > b_reg);
                    OP_LSH: res_next = (b_reg >= 64) ? '0 : a_reg << b_reg[5:0];
                    OP_RSH: res_next = (b_reg >= 64) ? '0 : rsh;
                    OP_LOG: begin
                        if (a_reg > 1) begin
                            a_next = a_reg >> 1;
                            acc_next = acc_reg + VAL_W'(1);
                            state_next = S_ITER;
                        end
                        res_next = acc_reg;
                    end
                    OP_NOT:  res_next = ~a_reg;
                    default: res_next = a_reg;
                endcase
            end
            S_WRITE: begin
                we = 1'b1;
                wdata = res_reg;
                unique case (opc_reg)
                    OP_IF: begin
                        waddr = AW'(depth_reg - DW'(3));
                        depth_next = depth_reg - DW'(2);
                    end
                    OP_LOG, OP_NOT: waddr = AW'(depth_reg - DW'(1));
                    OP_DUP: begin
                        waddr = depth_reg[AW-1:0];
                        depth_next = depth_reg + DW'(1);
                    end
                    OP_DROP: begin
                        waddr = '0;
                        wdata = '0;
                        we = (depth_reg == DW'(1));
                        if (depth_reg != DW'(1)) depth_next = depth_reg - DW'(1);
                    end
                    default: begin
                        waddr = AW'(depth_reg - DW'(2));
                        depth_next = depth_reg - DW'(1);
                    end
                endcase
                state_next = S_IDLE;
            end
            S_END: begin
                res_next = (st_reg == ST_OK) ? rdata : '0;
                mv_next = 1'b1;
                depth_next = '0;
                err_next = ST_OK;
                state_next = S_OUT;
            end
            S_OUT: begin
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            depth_reg <= '0;
            err_reg   <= ST_OK;
            mv_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            depth_reg <= depth_next;
            err_reg   <= err_next;
            mv_reg    <= mv_next;
        end
        opc_reg  <= opc_next;
        rcnt_reg <= rcnt_next;
        need_reg <= need_next;
        a_reg    <= a_next;
        b_reg    <= b_next;
        c_reg    <= c_next;
        acc_reg  <= acc_next;
        rem_reg  <= rem_next;
        cnt_reg  <= cnt_next;
        res_reg  <= res_next;
        st_reg   <= st_next;
    end

`ifndef NO_ASSERTIONS
    a_depth_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        depth_reg <= DW'(STACK_DEPTH - 1))
        else $error("stack depth out of range");
    a_ready_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tready |-> state_reg == S_IDLE)
        else $error("ready outside idle");
    a_out_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && st_reg != ST_OK) |-> res_reg == '0)
        else $error("nonzero value with error status");
    a_end_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_END |=> (depth_reg == '0 && err_reg == ST_OK && mv_reg))
        else $error("end beat did not clear the stack");
`endif

endmodule
